>>> rtl/core/csc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csc_pkg
// Shared widths, constants, arctan table and stage record for the CORDIC
// sine/cosine pipeline.
// ----------------------------------------------------------------------------
package csc_pkg;

  localparam int unsigned STEPS     = 6;
  localparam int unsigned ANGLE_W   = 12;
  localparam int unsigned OUT_W     = 14;
  localparam int unsigned XY_W      = 16;
  localparam int unsigned Z_W       = 14;
  localparam int unsigned FRAC_BITS = 12;
  localparam int unsigned PROD_W    = XY_W + Z_W;

  localparam logic signed [XY_W-1:0] SEED_X = 16'sh09B7;

  typedef struct packed {
    logic                   valid;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } csc_vec_t;

  function automatic logic signed [Z_W-1:0] atan_entry(input int unsigned i);
    logic signed [Z_W-1:0] r;
    begin
      case (i)
        0:       r = 14'sd511;
        1:       r = 14'sd302;
        2:       r = 14'sd159;
        3:       r = 14'sd81;
        4:       r = 14'sd41;
        5:       r = 14'sd20;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/csc_rotator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csc_rotator
// Rotation-mode CORDIC micro-rotations, one register stage per step.
// ----------------------------------------------------------------------------
module csc_rotator (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                adv,
  input  wire logic                                angle_valid,
  input  wire logic signed [csc_pkg::ANGLE_W-1:0]  angle,
  output csc_pkg::csc_vec_t                        vec_out
);

  csc_pkg::csc_vec_t seed;
  csc_pkg::csc_vec_t stg [csc_pkg::STEPS];

  always_comb begin
    seed.valid = angle_valid;
    seed.x     = csc_pkg::SEED_X;
    seed.y     = '0;
    seed.z     = csc_pkg::Z_W'(angle);
  end

  for (genvar k = 0; k < csc_pkg::STEPS; k++) begin : g_step
    csc_pkg::csc_vec_t src;
    csc_pkg::csc_vec_t stg_next;
    logic signed [csc_pkg::XY_W-1:0] xs;
    logic signed [csc_pkg::XY_W-1:0] ys;

    if (k == 0) begin : g_first
      assign src = seed;
    end else begin : g_rest
      assign src = stg[k-1];
    end

    always_comb begin
      xs             = src.x >>> k;
      ys             = src.y >>> k;
      stg_next.valid = src.valid;
      if (src.z < 0) begin
        stg_next.x = src.x + ys;
        stg_next.y = src.y - xs;
        stg_next.z = src.z + csc_pkg::atan_entry(k);
      end else begin
        stg_next.x = src.x - ys;
        stg_next.y = src.y + xs;
        stg_next.z = src.z - csc_pkg::atan_entry(k);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stg[k].valid <= 1'b0;
      end else if (adv) begin
        stg[k].valid <= stg_next.valid;
      end
      if (adv) begin
        stg[k].x <= stg_next.x;
        stg[k].y <= stg_next.y;
        stg[k].z <= stg_next.z;
      end
    end
  end

  assign vec_out = stg[csc_pkg::STEPS-1];

endmodule
`default_nettype wire

>>> rtl/core/csc_correct.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csc_correct
// Linear correction by the leftover residual: one product stage, one sum
// stage that also serves as the output register.
// ----------------------------------------------------------------------------
module csc_correct (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              adv,
  input  wire csc_pkg::csc_vec_t                 vec_in,
  output logic                                   result_valid,
  output logic signed [csc_pkg::OUT_W-1:0]       sine,
  output logic signed [csc_pkg::OUT_W-1:0]       cosine
);

  logic                               p_valid;
  logic signed [csc_pkg::XY_W-1:0]    p_x;
  logic signed [csc_pkg::XY_W-1:0]    p_y;
  logic signed [csc_pkg::PROD_W-1:0]  p_zx;
  logic signed [csc_pkg::PROD_W-1:0]  p_zy;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (adv) begin
      p_valid <= vec_in.valid;
    end
    if (adv) begin
      p_x  <= vec_in.x;
      p_y  <= vec_in.y;
      p_zx <= vec_in.z * vec_in.x;
      p_zy <= vec_in.z * vec_in.y;
    end
  end

  // only the low output bits are kept, so narrow operands suffice
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= p_valid;
    end
    if (adv) begin
      sine   <= p_y[csc_pkg::OUT_W-1:0]
              + p_zx[csc_pkg::FRAC_BITS+csc_pkg::OUT_W-1:csc_pkg::FRAC_BITS];
      cosine <= p_x[csc_pkg::OUT_W-1:0]
              - p_zy[csc_pkg::FRAC_BITS+csc_pkg::OUT_W-1:csc_pkg::FRAC_BITS];
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/cordic_sine_cosine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cordic_sine_cosine
// Six-step rotation-mode CORDIC sine/cosine of a signed 12-bit angle in units of 2^-12 turn.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+-------------------------
//   angle    | angle_valid / angle_stall   | angle  (s12)
//   result   | result_valid / result_stall | sine (s14), cosine (s14)
//
// One transfer per cycle in and out while the output is not stalled. There is
// one stage per CORDIC step, one product stage and one sum stage that is
// the output register. The whole pipeline advances together; it freezes only
// while a held result is stalled, and angle_stall follows that condition.
// Reset clears the valid bits only; the data registers are not reset.
// ----------------------------------------------------------------------------
module cordic_sine_cosine (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               angle_valid,
  output logic                                    angle_stall,
  input  wire logic signed [csc_pkg::ANGLE_W-1:0] angle,
  output logic                                    result_valid,
  input  wire logic                               result_stall,
  output logic signed [csc_pkg::OUT_W-1:0]        sine,
  output logic signed [csc_pkg::OUT_W-1:0]        cosine
);

  logic              adv;
  csc_pkg::csc_vec_t rot_vec;

  assign adv         = !(result_valid && result_stall);
  assign angle_stall = !adv;

  csc_rotator u_rotator (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .angle_valid (angle_valid),
    .angle       (angle),
    .vec_out     (rot_vec)
  );

  csc_correct u_correct (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .vec_in       (rot_vec),
    .result_valid (result_valid),
    .sine         (sine),
    .cosine       (cosine)
  );

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid straight after reset");

  a_empty_no_stall: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !angle_stall)
    else $error("input held back with empty output");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (angle_valid && !angle_stall) ##1 !angle_stall ##1 !angle_stall
      ##1 !angle_stall ##1 !angle_stall ##1 !angle_stall ##1 !angle_stall
      ##1 !angle_stall
      |=> result_valid)
    else $error("accepted angle did not reach the output");

endmodule
`default_nettype wire
